>>> hdl/isle_pkg.sv
// Shared types and codes for the indexed stack list engine.
package isle_pkg;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_GET    = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        we;
    logic [7:0]  waddr;
    logic [31:0] wdata;
    logic        re;
    logic [7:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  status;
    logic [4:0]  fill;
  } result_t;

endpackage

>>> hdl/isle_store.sv
// Entry memory: one write port, one read port with registered read data.
module isle_store #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  isle_pkg::mem_req_t req,
  output logic [31:0]        rdata
);
  import isle_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic [31:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr[AW-1:0]];
    end
  end

endmodule

>>> hdl/isle_ctrl.sv
// Command sequencer: fill count, range checks and the shift-down loop for remove.
module isle_ctrl #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [7:0]         index,
  input  logic [31:0]        value,
  output isle_pkg::mem_req_t req,
  input  logic [31:0]        rdata,
  output logic               res_valid,
  input  logic               res_take,
  output isle_pkg::result_t  res
);
  import isle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SHRD = 3'd2;
  localparam logic [2:0] S_SHWR = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]    state;
  logic [1:0]    cmd;
  logic [7:0]    idx;
  logic [31:0]   data;
  logic [1:0]    stat;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;

  logic          accept;
  logic [XW-1:0] index_ext;
  logic [XW-1:0] idx_ext;
  logic [XW-1:0] count_ext;
  logic [XW-1:0] idx_inc;
  logic [CW-1:0] ptr_inc;

  assign accept    = in_valid && (state == S_IDLE);
  assign in_stall  = (state != S_IDLE);
  assign index_ext = XW'(index);
  assign idx_ext   = XW'(idx);
  assign count_ext = XW'(count);
  assign idx_inc   = idx_ext + XW'(1);
  assign ptr_inc   = ptr + CW'(1);

  always_comb begin
    req = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (command)
            CMD_PUSH: begin
              req.we    = (count < CAP);
              req.waddr = 8'(count);
              req.wdata = value;
            end
            CMD_POP: begin
              req.re    = 1'b1;
              req.raddr = 8'(count - CW'(1));
            end
            default: begin
              req.re    = 1'b1;
              req.raddr = index;
            end
          endcase
        end
      end
      S_SHRD: begin
        req.re    = 1'b1;
        req.raddr = 8'(ptr);
      end
      S_SHWR: begin
        req.we    = 1'b1;
        req.waddr = 8'(ptr - CW'(1));
        req.wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd  <= command;
            idx  <= index;
            data <= '0;
            unique case (command)
              CMD_PUSH: begin
                if (count >= CAP) begin
                  stat <= ST_FULL;
                end else begin
                  stat  <= ST_OK;
                  count <= count + CW'(1);
                end
                state <= S_DONE;
              end
              CMD_POP: begin
                if (count == '0) begin
                  stat  <= ST_EMPTY;
                  state <= S_DONE;
                end else begin
                  stat  <= ST_OK;
                  count <= count - CW'(1);
                  state <= S_READ;
                end
              end
              default: begin
                if (index_ext >= count_ext) begin
                  stat  <= ST_EMPTY;
                  state <= S_DONE;
                end else begin
                  stat  <= ST_OK;
                  state <= S_READ;
                end
              end
            endcase
          end
        end
        S_READ: begin
          data <= rdata;
          if (cmd == CMD_REMOVE) begin
            if (idx_inc < count_ext) begin
              ptr   <= CW'(idx_inc);
              state <= S_SHRD;
            end else begin
              count <= count - CW'(1);
              state <= S_DONE;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_SHRD: begin
          state <= S_SHWR;
        end
        S_SHWR: begin
          ptr <= ptr_inc;
          if (ptr_inc < count) begin
            state <= S_SHRD;
          end else begin
            count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res_valid   = (state == S_DONE);
  assign res.data    = data;
  assign res.status  = stat;
  assign res.fill    = count_ext[4:0];

endmodule

>>> hdl/indexed_stack_list_engine_core.sv
// Top level of the indexed stack list engine: sequencer, entry memory, output register.
//
//   channel | signals                                  | direction
//   input   | in_valid, in_stall, command, index, value | in (in_stall out)
//   output  | out_valid, out_stall, data_out, status,   | out (out_stall in)
//           | fill_count                               |
//
// A push, or any command rejected by the range check, goes from idle straight to
// done; pop, get and remove pass through the read state, and remove at index i
// then runs count - i - 1 read/write pairs, one entry move per pair on the single read port.
// One word is held in the output register; the input is taken again once the
// result has moved there, so while the output stalls one more item is taken
// and finished, then the input stalls until the output register drains.
// Reset empties the list at once; memory contents are left as they are.
module indexed_stack_list_engine_core #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  index,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] data_out,
  output logic [1:0]  status,
  output logic [4:0]  fill_count
);
  import isle_pkg::*;

  mem_req_t    req;
  logic [31:0] rdata;
  logic        res_valid;
  logic        res_take;
  result_t     res;

  isle_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .index     (index),
    .value     (value),
    .req       (req),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  isle_store #(.CAPACITY(CAPACITY)) u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      data_out   <= res.data;
      status     <= res.status;
      fill_count <= res.fill;
    end
  end

endmodule

>>> test/testbench.sv
// Self-checking testbench for the indexed stack list engine: directed table, then random words.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import isle_pkg::*;

  localparam int CAP = 16;
  localparam int RANDOM_WORDS = 400;
  localparam int DIR_ROWS = 19;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  idx;
    logic [31:0] val;
    logic [4:0]  reps;
    logic        known;
    result_t     want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_PUSH;
  logic [7:0]  index = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] data_out;
  logic [1:0]  status;
  logic [4:0]  fill_count;

  logic [31:0] list_handles [CAP];
  int          list_len = 0;
  result_t     pending_results [$];
  dir_row_t    dir_rows [DIR_ROWS];

  int errors = 0;
  int words_sent = 0;
  int words_got = 0;
  int full_seen = 0;
  int range_seen = 0;

  indexed_stack_list_engine_core #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .index(index), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .data_out(data_out), .status(status), .fill_count(fill_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

  // list behavior: updates the shadow list and returns the result word
  function automatic result_t apply_list_op(logic [1:0] cmd, logic [7:0] idx,
                                            logic [31:0] val);
    result_t r;
    int i;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (list_len >= CAP) r.status = ST_FULL;
        else begin
          list_handles[list_len] = val;
          list_len++;
        end
      end
      CMD_POP: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else begin
          list_len--;
          r.data = list_handles[list_len];
        end
      end
      default: begin
        if (int'(idx) >= list_len) r.status = ST_EMPTY;
        else begin
          r.data = list_handles[idx];
          if (cmd == CMD_REMOVE) begin
            for (i = int'(idx) + 1; i < list_len; i++) list_handles[i-1] = list_handles[i];
            list_len--;
          end
        end
      end
    endcase
    r.fill = 5'(list_len);
    return r;
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [7:0] idx,
                           input logic [31:0] val, input logic known, input result_t want);
    int gap;
    result_t r;
    gap = (((words_sent / 40) % 3) == 2) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    index <= idx;
    value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = apply_list_op(cmd, idx, val);
    pending_results.push_back(known ? want : r);
    words_sent++;
  endtask

  // output side: random stall per word, one long hold to back up the input
  initial begin
    int hold;
    forever begin
      hold = (((words_got / 48) % 3) == 1) ? 0 : $urandom_range(0, 17);
      if (words_got == 150) hold = 120;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      words_got++;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word data=%h status=%0d fill=%0d",
                 $time, data_out, status, fill_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (data_out !== want.data) begin
          $display("%0t: data_out expected %h actual %h", $time, want.data, data_out);
          errors++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
        if (fill_count !== want.fill) begin
          $display("%0t: fill_count expected %0d actual %0d", $time, want.fill, fill_count);
          errors++;
        end
        if (status === ST_FULL) full_seen++;
        if (status === ST_EMPTY) range_seen++;
      end
    end
  end

  initial begin
    int r, k, waited, push_pct, pick;
    logic [1:0] cmd;
    logic [7:0] idx;
    logic [31:0] val;

    dir_rows = '{
      '{CMD_POP,    8'd0,   32'd0,         5'd1,  1'b1, '{32'd0, ST_EMPTY, 5'd0}},
      '{CMD_GET,    8'd0,   32'd0,         5'd1,  1'b1, '{32'd0, ST_EMPTY, 5'd0}},
      '{CMD_REMOVE, 8'd255, 32'd0,         5'd1,  1'b1, '{32'd0, ST_EMPTY, 5'd0}},
      '{CMD_PUSH,   8'd0,   32'hFFFFFFFF,  5'd1,  1'b1, '{32'd0, ST_OK, 5'd1}},
      '{CMD_PUSH,   8'd255, 32'd0,         5'd1,  1'b1, '{32'd0, ST_OK, 5'd2}},
      '{CMD_GET,    8'd0,   32'd0,         5'd1,  1'b1, '{32'hFFFFFFFF, ST_OK, 5'd2}},
      '{CMD_GET,    8'd1,   32'd0,         5'd1,  1'b1, '{32'd0, ST_OK, 5'd2}},
      '{CMD_GET,    8'd2,   32'd0,         5'd1,  1'b1, '{32'd0, ST_EMPTY, 5'd2}},
      '{CMD_REMOVE, 8'd0,   32'd0,         5'd1,  1'b1, '{32'hFFFFFFFF, ST_OK, 5'd1}},
      '{CMD_POP,    8'd0,   32'd0,         5'd1,  1'b1, '{32'd0, ST_OK, 5'd0}},
      '{CMD_PUSH,   8'd0,   32'hA5A50000,  5'd16, 1'b0, '0},
      '{CMD_PUSH,   8'd0,   32'h5A5A5A5A,  5'd1,  1'b1, '{32'd0, ST_FULL, 5'd16}},
      '{CMD_GET,    8'd15,  32'd0,         5'd1,  1'b0, '0},
      '{CMD_REMOVE, 8'd15,  32'd0,         5'd1,  1'b0, '0},
      '{CMD_REMOVE, 8'd0,   32'd0,         5'd1,  1'b0, '0},
      '{CMD_GET,    8'd255, 32'd0,         5'd1,  1'b1, '{32'd0, ST_EMPTY, 5'd14}},
      '{CMD_GET,    8'd14,  32'd0,         5'd1,  1'b1, '{32'd0, ST_EMPTY, 5'd14}},
      '{CMD_REMOVE, 8'd7,   32'd0,         5'd1,  1'b0, '0},
      '{CMD_POP,    8'd0,   32'd0,         5'd1,  1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      for (r = 0; r < int'(dir_rows[i].reps); r++)
        send_word(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].val + 32'(r),
                  dir_rows[i].known, dir_rows[i].want);
    end

    // alternate fill-heavy and drain-heavy stretches so both ends are hit
    for (k = 0; k < RANDOM_WORDS; k++) begin
      push_pct = ((k / 50) % 2) ? 65 : 30;
      if ($urandom_range(0, 99) < push_pct) cmd = CMD_PUSH;
      else begin
        case ($urandom_range(0, 2))
          0: cmd = CMD_POP;
          1: cmd = CMD_GET;
          default: cmd = CMD_REMOVE;
        endcase
      end
      pick = $urandom_range(0, 9);
      if (pick == 0 || list_len == 0) idx = 8'($urandom_range(0, 255));
      else if (pick == 1) idx = 8'(list_len);
      else idx = 8'($urandom_range(0, list_len - 1));
      case ($urandom_range(0, 15))
        0: val = 32'd0;
        1: val = 32'hFFFFFFFF;
        default: val = $urandom;
      endcase
      send_word(cmd, idx, val, 1'b0, '0);
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_results.size());
      errors++;
    end

    $display("Sent %0d words (directed table plus %0d random), checked %0d results.",
             words_sent, RANDOM_WORDS, words_got);
    $display("Saw %0d full and %0d empty/out-of-range rejects, with one long output hold.",
             full_seen, range_seen);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
